// File: sv/geodetic_to_ecef_defines.svh
`ifndef GEODETIC_TO_ECEF_DEFINES_SVH
`define GEODETIC_TO_ECEF_DEFINES_SVH

// checks that are off while rst_n is low
`define G2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checks that also hold through reset
`define G2E_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/g2e_pkg.sv
package g2e_pkg;

  localparam logic [63:0]        DEG_TO_RAD_Q64 = 64'd321956420358983237;
  localparam logic signed [63:0] CORDIC_GAIN    = 64'sd700114967507363239;
  localparam logic signed [63:0] ATAN_ONE       = 64'sh0C90FDAA22168C23;
  localparam logic signed [63:0] ONE_Q60        = 64'sd1152921504606846976;
  localparam int                 SQRT_BITS      = 57;
  localparam int                 DIV_BITS       = 64;
  localparam logic [62:0]        RADIUS_CAP     = 63'd4611686018427387904;
  localparam logic [48:0]        OUT_LIMIT      = 49'd6600000000;
  localparam logic [32:0]        AXIS_RESET     = 33'd6378137000;
  localparam logic [47:0]        ECC_RESET      = 48'd1884300451806;

  // register indexes on the config port
  localparam logic CFG_AXIS = 1'b0;
  localparam logic CFG_ECC  = 1'b1;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } rot_t;

  typedef struct packed {
    logic [56:0]  root;
    logic [112:0] rem;
  } sqrt_t;

  typedef struct packed {
    logic [56:0] d;
    logic [56:0] rn;
    logic [56:0] rm;
    logic [63:0] qn;
    logic [63:0] qm;
  } div_t;

  typedef struct packed {
    logic [1:0] quad;
    logic [6:0] rem;
  } wrap_t;

  // whole degrees modulo 360, split into quadrant and remainder
  function automatic wrap_t wrap_deg(logic signed [8:0] whole);
    logic signed [9:0] v;
    logic [8:0]        u;
    wrap_t             w;
    v = 10'(whole);
    if (v < 10'sd0) v = v + 10'sd360;
    u = v[8:0];
    priority if (u >= 9'd270) begin
      w.quad = 2'd3;
      w.rem  = 7'(u - 9'd270);
    end else if (u >= 9'd180) begin
      w.quad = 2'd2;
      w.rem  = 7'(u - 9'd180);
    end else if (u >= 9'd90) begin
      w.quad = 2'd1;
      w.rem  = 7'(u - 9'd90);
    end else begin
      w.quad = 2'd0;
      w.rem  = u[6:0];
    end
    return w;
  endfunction

  function automatic logic signed [61:0] clamp_q60(logic signed [63:0] v);
    logic signed [61:0] r;
    if (v < 64'sd0)          r = '0;
    else if (v > ONE_Q60)    r = 62'(ONE_Q60);
    else                     r = 62'(v);
    return r;
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    logic [63:0] u;
    u = v;
    return v[63] ? (64'd0 - u) : u;
  endfunction

  function automatic logic signed [63:0] apply_sign(logic neg, logic [63:0] m);
    logic signed [63:0] s;
    s = m;
    return neg ? -s : s;
  endfunction

  // 16 fraction bits to whole mm, half away from zero, saturated
  function automatic logic [33:0] to_mm(logic signed [63:0] v16);
    logic [63:0] m;
    logic [48:0] r;
    m = mag64(v16);
    r = {1'b0, m[63:16]} + 49'(m[15]);
    if (r > OUT_LIMIT) r = OUT_LIMIT;
    return v16[63] ? (34'd0 - r[33:0]) : r[33:0];
  endfunction

endpackage

// File: sv/g2e_mul.sv
module g2e_mul (
  input  logic         clk,
  input  logic         en,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  // four 32x32 partial products, registered, then summed into the product register
  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [127:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[31:0]  * b[31:0];
      lh_r <= a[31:0]  * b[63:32];
      hl_r <= a[63:32] * b[31:0];
      hh_r <= a[63:32] * b[63:32];
      p_r  <= {hh_r, 64'd0} + ({64'd0, lh_r} << 32) + ({64'd0, hl_r} << 32)
            + {64'd0, ll_r};
    end
  end

  assign p = p_r;

endmodule

// File: sv/g2e_delay.sv
module g2e_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

// File: sv/g2e_cordic_cell.sv
module g2e_cordic_cell import g2e_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic       clk,
  input  logic       en,
  input  rot_t [1:0] rot_i,
  output rot_t [1:0] rot_o
);

  localparam int NTERM = 30;

  logic signed [63:0] term [NTERM];
  logic signed [63:0] atan_c;
  rot_t [1:0]         rot_r, rot_nxt;

  // atan(2^-STAGE) as its alternating series, folded at elaboration
  for (genvar k = 0; k < NTERM; k++) begin : g_term
    localparam int EXPO  = STAGE * (2 * k + 1);
    localparam int SHAMT = (EXPO > 60) ? 0 : 60 - EXPO;
    localparam logic signed [63:0] MAGN =
      (EXPO > 60) ? 64'sd0 : (64'sd1 <<< SHAMT) / (2 * k + 1);
    assign term[k] = (k % 2 == 1) ? -MAGN : MAGN;
  end

  always_comb begin
    logic signed [63:0] acc;
    acc = '0;
    for (int k = 0; k < NTERM; k++) acc = acc + term[k];
    atan_c = (STAGE == 0) ? ATAN_ONE : acc;
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      if (!rot_i[j].z[63]) begin
        rot_nxt[j].x = rot_i[j].x - (rot_i[j].y >>> STAGE);
        rot_nxt[j].y = rot_i[j].y + (rot_i[j].x >>> STAGE);
        rot_nxt[j].z = rot_i[j].z - atan_c;
      end else begin
        rot_nxt[j].x = rot_i[j].x + (rot_i[j].y >>> STAGE);
        rot_nxt[j].y = rot_i[j].y - (rot_i[j].x >>> STAGE);
        rot_nxt[j].z = rot_i[j].z + atan_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) rot_r <= rot_nxt;
  end

  assign rot_o = rot_r;

endmodule

// File: sv/g2e_sqrt_cell.sv
module g2e_sqrt_cell import g2e_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t sq_i,
  output sqrt_t sq_o
);

  logic [114:0] trial;
  logic [114:0] rem_x;
  sqrt_t        sq_r, sq_nxt;

  // (root + 2^BIT)^2 - root^2 = root*2^(BIT+1) + 2^(2*BIT)
  always_comb begin
    trial  = ({58'd0, sq_i.root} << (BIT + 1)) | (115'd1 << (2 * BIT));
    rem_x  = {2'b00, sq_i.rem};
    sq_nxt = sq_i;
    if (rem_x >= trial) begin
      sq_nxt.rem  = sq_i.rem - trial[112:0];
      sq_nxt.root = sq_i.root | (57'd1 << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) sq_r <= sq_nxt;
  end

  assign sq_o = sq_r;

endmodule

// File: sv/g2e_div_cell.sv
module g2e_div_cell import g2e_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] lo_m,
  input  div_t        dv_i,
  output div_t        dv_o
);

  logic [57:0] shn, shm, dx;
  div_t        dv_r, dv_nxt;

  // one restoring step for N and M; N's low dividend word is zero
  always_comb begin
    dx     = {1'b0, dv_i.d};
    shn    = {dv_i.rn, 1'b0};
    shm    = {dv_i.rm, lo_m[BIT]};
    dv_nxt = dv_i;
    if (shn >= dx) begin
      dv_nxt.rn      = 57'(shn - dx);
      dv_nxt.qn[BIT] = 1'b1;
    end else begin
      dv_nxt.rn = shn[56:0];
    end
    if (shm >= dx) begin
      dv_nxt.rm      = 57'(shm - dx);
      dv_nxt.qm[BIT] = 1'b1;
    end else begin
      dv_nxt.rm = shm[56:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) dv_r <= dv_nxt;
  end

  assign dv_o = dv_r;

endmodule

// File: sv/geodetic_to_ecef.sv
// Throughput: one beat per cycle; every stage is a register, so a new point
// enters each cycle the output register is free or being drained.
// Reset (rst_n low at a clock edge): all stage valids and out_tvalid clear,
// the ellipsoid registers load WGS84 (a = 6378137000 mm, e2 = 1884300451806).
module geodetic_to_ecef import g2e_pkg::*; #(
  parameter int CORDIC_STAGES = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  // latitude[39:0], longitude[80:40], height_first[108:81],
  // height_second[136:109], zero fill
  input  logic [143:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tlast,
  // x_first[33:0], y_first[67:34], z_first[101:68], x_second[135:102],
  // y_second[169:136], z_second[203:170], zero fill
  output logic [207:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [47:0]  cfg_data
);

  // Stage map (P1 = input register):
  //   P1..P3           angle reduction, degrees to radians
  //   P4..P3+CS        CORDIC rotation, one cell per iteration
  //   P4+CS            clamp and quadrant fold
  //   P5+CS..P9+CS     sin^2, e2*sin^2, w
  //   P10+CS..P66+CS   square root, one result bit per cell
  //   P67+CS           divider setup and overflow check
  //   P68+CS..P131+CS  N and M divisions, one quotient bit per cell
  //   P132+CS..P137+CS radius plus height, products with trig terms
  localparam int CS  = CORDIC_STAGES;
  localparam int NST = CS + 137;

  logic adv;
  logic in_acc;

  logic [NST-1:0] vld_r;

  logic [32:0] axis_r;
  logic [47:0] ecc_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= AXIS_RESET;
      ecc_r  <= ECC_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_AXIS: axis_r <= cfg_data[32:0];
        CFG_ECC:  ecc_r  <= cfg_data;
      endcase
    end
  end

  // a * (1 - e2) scaled by 2^48; only changes on config writes
  logic [127:0] pcfg;
  logic [48:0]  one_m_e2;
  assign one_m_e2 = {1'b1, 48'd0} - {1'b0, ecc_r};

  g2e_mul u_mul_cfg (
    .clk (clk), .en (1'b1),
    .a   ({31'd0, axis_r}), .b ({15'd0, one_m_e2}),
    .p   (pcfg)
  );

  // ---------------- flow control ----------------
  // the whole pipe moves whenever the output register can take a beat
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_acc};
    end
  end

  // ---------------- P1: angle reduction ----------------
  wrap_t wlat, wlon;
  assign wlat = wrap_deg(9'(signed'(in_tdata[39:32])));
  assign wlon = wrap_deg(signed'(in_tdata[80:72]));

  logic [38:0] rlat_r, rlon_r;
  logic [1:0]  qlat_r, qlon_r;
  logic [27:0] h1_r, h2_r;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rlat_r <= {wlat.rem, in_tdata[31:0]};
      rlon_r <= {wlon.rem, in_tdata[71:40]};
      qlat_r <= wlat.quad;
      qlon_r <= wlon.quad;
      h1_r   <= in_tdata[108:81];
      h2_r   <= in_tdata[136:109];
      last_r <= in_tlast;
    end
  end

  // ---------------- P2..P3: degrees to radians, 2^-60 ----------------
  logic [127:0] pzlat, pzlon;

  g2e_mul u_mul_zlat (
    .clk (clk), .en (adv), .a ({25'd0, rlat_r}), .b (DEG_TO_RAD_Q64), .p (pzlat)
  );
  g2e_mul u_mul_zlon (
    .clk (clk), .en (adv), .a ({25'd0, rlon_r}), .b (DEG_TO_RAD_Q64), .p (pzlon)
  );

  // ---------------- CORDIC row ----------------
  rot_t [1:0] rot_c [CS+1];

  assign rot_c[0][0] = {CORDIC_GAIN, 64'd0, pzlat[99:36]};
  assign rot_c[0][1] = {CORDIC_GAIN, 64'd0, pzlon[99:36]};

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    g2e_cordic_cell #(.STAGE(i)) u_cell (
      .clk (clk), .en (adv), .rot_i (rot_c[i]), .rot_o (rot_c[i+1])
    );
  end

  logic [3:0] quad_d;
  g2e_delay #(.WIDTH(4), .DEPTH(CS + 2)) u_dly_quad (
    .clk (clk), .en (adv), .d ({qlon_r, qlat_r}), .q (quad_d)
  );

  // ---------------- P4+CS: clamp and quadrant ----------------
  logic signed [61:0] cl_r, sl_r, co_r, so_r;
  logic signed [61:0] c0 [2];
  logic signed [61:0] s0 [2];
  logic signed [61:0] cq [2];
  logic signed [61:0] sq [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      c0[j] = clamp_q60(rot_c[CS][j].x);
      s0[j] = clamp_q60(rot_c[CS][j].y);
      unique case (quad_d[2*j +: 2])
        2'd0: begin cq[j] = c0[j];  sq[j] = s0[j];  end
        2'd1: begin cq[j] = -s0[j]; sq[j] = c0[j];  end
        2'd2: begin cq[j] = -c0[j]; sq[j] = -s0[j]; end
        2'd3: begin cq[j] = s0[j];  sq[j] = -c0[j]; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cl_r <= cq[0];
      sl_r <= sq[0];
      co_r <= cq[1];
      so_r <= sq[1];
    end
  end

  // ---------------- P5+CS..P9+CS: w = 1 - e2 sin^2 ----------------
  logic [127:0] ps2, pes;
  logic [48:0]  w_r;

  g2e_mul u_mul_s2 (
    .clk (clk), .en (adv), .a (mag64(64'(sl_r))), .b (mag64(64'(sl_r))), .p (ps2)
  );
  g2e_mul u_mul_es (
    .clk (clk), .en (adv), .a ({16'd0, ecc_r}), .b ({3'd0, ps2[120:60]}), .p (pes)
  );

  always_ff @(posedge clk) begin
    if (adv) w_r <= {1'b1, 48'd0} - pes[108:60];
  end

  // ---------------- square root row ----------------
  sqrt_t sq_c [SQRT_BITS+1];
  assign sq_c[0] = {57'd0, w_r, 64'd0};

  for (genvar i = 0; i < SQRT_BITS; i++) begin : g_sqrt
    g2e_sqrt_cell #(.BIT(SQRT_BITS - 1 - i)) u_cell (
      .clk (clk), .en (adv), .sq_i (sq_c[i]), .sq_o (sq_c[i+1])
    );
  end

  // ---------------- P67+CS: divider setup ----------------
  logic [63:0] hi_n, hi_m, lo_m, rt64;
  div_t        dv_set_r;
  logic [1:0]  cap_r;

  assign hi_n = {23'd0, axis_r, 8'd0};
  assign hi_m = pcfg[103:40];
  assign lo_m = {pcfg[39:0], 24'd0};
  assign rt64 = {7'd0, sq_c[SQRT_BITS].root};

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_set_r <= {sq_c[SQRT_BITS].root, hi_n[56:0], hi_m[56:0], 64'd0, 64'd0};
      // quotient would not fit: result is the radius cap
      cap_r    <= {hi_m >= rt64, hi_n >= rt64};
    end
  end

  // ---------------- division row ----------------
  div_t dv_c [DIV_BITS+1];
  assign dv_c[0] = dv_set_r;

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    g2e_div_cell #(.BIT(DIV_BITS - 1 - i)) u_cell (
      .clk (clk), .en (adv), .lo_m (lo_m), .dv_i (dv_c[i]), .dv_o (dv_c[i+1])
    );
  end

  logic [1:0] cap_d;
  g2e_delay #(.WIDTH(2), .DEPTH(DIV_BITS)) u_dly_cap (
    .clk (clk), .en (adv), .d (cap_r), .q (cap_d)
  );

  logic [55:0] h_d;
  g2e_delay #(.WIDTH(56), .DEPTH(CS + 130)) u_dly_h (
    .clk (clk), .en (adv), .d ({h2_r, h1_r}), .q (h_d)
  );

  // ---------------- P132+CS: radius plus height ----------------
  logic [62:0]        n16, m16;
  logic signed [63:0] hq [2];
  logic signed [63:0] rn_r [2];
  logic signed [63:0] rm_r [2];

  always_comb begin
    n16 = (cap_d[0] || dv_c[DIV_BITS].qn > {1'b0, RADIUS_CAP}) ? RADIUS_CAP
        : dv_c[DIV_BITS].qn[62:0];
    m16 = (cap_d[1] || dv_c[DIV_BITS].qm > {1'b0, RADIUS_CAP}) ? RADIUS_CAP
        : dv_c[DIV_BITS].qm[62:0];
    hq[0] = 64'(signed'(h_d[27:0]))  <<< 16;
    hq[1] = 64'(signed'(h_d[55:28])) <<< 16;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        rn_r[k] <= signed'({1'b0, n16}) + hq[k];
        rm_r[k] <= signed'({1'b0, m16}) + hq[k];
      end
    end
  end

  logic [123:0] clsl_d;
  logic [123:0] coso_d;
  logic signed [61:0] cl_d, sl_d, co_d, so_d;

  g2e_delay #(.WIDTH(124), .DEPTH(128)) u_dly_clsl (
    .clk (clk), .en (adv), .d ({sl_r, cl_r}), .q (clsl_d)
  );
  g2e_delay #(.WIDTH(124), .DEPTH(131)) u_dly_coso (
    .clk (clk), .en (adv), .d ({so_r, co_r}), .q (coso_d)
  );

  assign cl_d = signed'(clsl_d[61:0]);
  assign sl_d = signed'(clsl_d[123:62]);
  assign co_d = signed'(coso_d[61:0]);
  assign so_d = signed'(coso_d[123:62]);

  // ---------------- P133+CS..P135+CS: (N+h) cos lat, (M+h) sin lat ------
  logic [127:0] pa_n [2];
  logic [127:0] pa_m [2];
  logic [3:0]   sa, sa_d;
  logic signed [63:0] t_r [2];
  logic signed [63:0] zq_r [2];

  for (genvar k = 0; k < 2; k++) begin : g_mul_a
    g2e_mul u_mul_n (
      .clk (clk), .en (adv), .a (mag64(rn_r[k])), .b (mag64(64'(cl_d))), .p (pa_n[k])
    );
    g2e_mul u_mul_m (
      .clk (clk), .en (adv), .a (mag64(rm_r[k])), .b (mag64(64'(sl_d))), .p (pa_m[k])
    );
    assign sa[2*k]   = rn_r[k][63] ^ cl_d[61];
    assign sa[2*k+1] = rm_r[k][63] ^ sl_d[61];
  end

  g2e_delay #(.WIDTH(4), .DEPTH(2)) u_dly_sa (
    .clk (clk), .en (adv), .d (sa), .q (sa_d)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        t_r[k]  <= apply_sign(sa_d[2*k],   pa_n[k][123:60]);
        zq_r[k] <= apply_sign(sa_d[2*k+1], pa_m[k][123:60]);
      end
    end
  end

  // ---------------- P136+CS..P137+CS: times cos lon, sin lon --------------
  logic [127:0] pb_x [2];
  logic [127:0] pb_y [2];
  logic [3:0]   sb, sb_d;
  logic [127:0] zq_d;

  for (genvar k = 0; k < 2; k++) begin : g_mul_b
    g2e_mul u_mul_x (
      .clk (clk), .en (adv), .a (mag64(t_r[k])), .b (mag64(64'(co_d))), .p (pb_x[k])
    );
    g2e_mul u_mul_y (
      .clk (clk), .en (adv), .a (mag64(t_r[k])), .b (mag64(64'(so_d))), .p (pb_y[k])
    );
    assign sb[2*k]   = t_r[k][63] ^ co_d[61];
    assign sb[2*k+1] = t_r[k][63] ^ so_d[61];
  end

  g2e_delay #(.WIDTH(4), .DEPTH(2)) u_dly_sb (
    .clk (clk), .en (adv), .d (sb), .q (sb_d)
  );
  g2e_delay #(.WIDTH(128), .DEPTH(2)) u_dly_zq (
    .clk (clk), .en (adv), .d ({zq_r[1], zq_r[0]}), .q (zq_d)
  );

  logic last_d;
  g2e_delay #(.WIDTH(1), .DEPTH(CS + 136)) u_dly_last (
    .clk (clk), .en (adv), .d (last_r), .q (last_d)
  );

  // ---------------- output register ----------------
  logic [33:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r       <= to_mm(apply_sign(sb_d[0], pb_x[0][123:60]));
      y1_r       <= to_mm(apply_sign(sb_d[1], pb_y[0][123:60]));
      z1_r       <= to_mm(signed'(zq_d[63:0]));
      x2_r       <= to_mm(apply_sign(sb_d[2], pb_x[1][123:60]));
      y2_r       <= to_mm(apply_sign(sb_d[3], pb_y[1][123:60]));
      z2_r       <= to_mm(signed'(zq_d[127:64]));
      out_last_r <= last_d;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, z2_r, y2_r, x2_r, z1_r, y1_r, x1_r};

endmodule

// File: sv/g2e_chk.sv
`include "geodetic_to_ecef_defines.svh"

module g2e_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic [207:0] out_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic         out_tlast
);

  // input side only stalls while a finished point is held at the output
  `G2E_ASSERT(a_ready_tracks_out, in_tready == (!out_tvalid || out_tready), "in_tready wrong")

  `G2E_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled beat changed")

  `G2E_ASSERT(a_x_range, out_tvalid |-> ($signed(out_tdata[33:0]) >= -34'sd6600000000) && ($signed(out_tdata[33:0]) <= 34'sd6600000000), "x_first not saturated")

  `G2E_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_tvalid, "out_tvalid after reset")

endmodule

bind geodetic_to_ecef g2e_chk u_g2e_chk (.*);

// File: dv/tb_geodetic_to_ecef.sv
`timescale 1ns / 1ps

module tb_geodetic_to_ecef;
  import g2e_pkg::*;

  localparam longint LAT_MAX   = 64'sd386547056640;
  localparam longint LON_MAX   = 64'sd773094113280;
  localparam longint H_MAX     = 64'sd100000000;
  localparam longint DEG90_Q32 = 64'sd90 <<< 32;
  localparam longint DEG360_Q32 = 64'sd360 <<< 32;
  localparam longint GAIN_Q60  = 64'sd700114967507363239;
  localparam longint UNIT_Q60  = 64'sd1 <<< 60;
  localparam longint SAT_MM    = 64'sd6600000000;
  localparam logic [63:0] CAP_Q16 = 64'd1 << 62;
  localparam int     LATENCY   = 40 + 138;
  localparam int     CYCLE_LIMIT = 2000000;

  // one result beat split into fields
  typedef struct packed {
    logic signed [33:0] x_first;
    logic signed [33:0] y_first;
    logic signed [33:0] z_first;
    logic signed [33:0] x_second;
    logic signed [33:0] y_second;
    logic signed [33:0] z_second;
    logic               last_point;
  } ecef_t;

  logic         clk;
  logic         rst_n;
  logic [143:0] in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic         in_tlast;
  logic [207:0] out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [47:0]  cfg_data;

  // ellipsoid as the predictor sees it
  logic [32:0] axis_mm;
  logic [47:0] ecc_q48;

  ecef_t ecef_due[$];
  int    errors = 0;
  int    points_sent;
  int    points_checked = 0;
  int    cycles = 0;
  int    send_idle_pct;
  int    recv_stall_pct;

  geodetic_to_ecef dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the conversion
  // ---------------------------------------------------------------------------

  // floor(a*b / 2^s), capped at the largest positive 64-bit value
  function automatic logic [63:0] umul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    return (p > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  // sign-magnitude product, truncated toward zero
  function automatic longint smul_shift(longint a, longint b, int s);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    r  = umul_shift(ma, mb, s);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  // atan(2^-i) at scale 2^-60 from its alternating series
  function automatic longint atan_q60(int i);
    longint acc;
    longint t;
    int     k;
    if (i == 0) return 64'sh0C90FDAA22168C23;
    acc = 0;
    for (k = 0; i * (2 * k + 1) <= 60; k++) begin
      t   = (64'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
      acc = (k % 2) ? acc - t : acc + t;
    end
    return acc;
  endfunction

  // cosine and sine at scale 2^-60 of an angle in degrees * 2^32
  task automatic cos_sin(input longint deg, output longint c, output longint s);
    longint r, x, y, z, dx, dy, c0, s0;
    int     quad;
    r = deg % DEG360_Q32;
    if (r < 0) r += DEG360_Q32;
    quad = int'(r / DEG90_Q32);
    r -= longint'(quad) * DEG90_Q32;
    z = longint'(umul_shift(r, DEG_TO_RAD_Q64, 36));
    x = GAIN_Q60;
    y = 0;
    for (int i = 0; i < 40; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q60(i);
      end else begin
        x += dx; y -= dy; z += atan_q60(i);
      end
    end
    c0 = (x < 0) ? 0 : ((x > UNIT_Q60) ? UNIT_Q60 : x);
    s0 = (y < 0) ? 0 : ((y > UNIT_Q60) ? UNIT_Q60 : y);
    case (quad)
      0: begin c = c0;  s = s0;  end
      1: begin c = -s0; s = c0;  end
      2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
  endtask

  function automatic logic [63:0] div_capped(logic [127:0] num, logic [63:0] d);
    logic [127:0] q;
    if (num[127:64] >= d) return CAP_Q16;
    q = num / {64'd0, d};
    return (q[63:0] > CAP_Q16) ? CAP_Q16 : q[63:0];
  endfunction

  // 16 fraction bits to whole mm, half away from zero, saturated
  function automatic logic signed [33:0] round_mm(longint v16);
    logic [63:0] m;
    m = (v16 < 0) ? -v16 : v16;
    m = (m >> 16) + ((m >> 15) & 64'd1);
    if (m > SAT_MM) m = SAT_MM;
    return (v16 < 0) ? 34'(-longint'(m)) : 34'(m);
  endfunction

  task automatic convert_point(input logic [143:0] pt, input logic last, output ecef_t res);
    longint       cl, sl, co, so, rn, rm, t;
    longint       hgt [2];
    logic [63:0]  s2, w, rt, tt_bit, n16, m16, slm;
    logic [127:0] tt, p;
    cos_sin(longint'($signed(pt[39:0])), cl, sl);
    cos_sin(longint'($signed(pt[80:40])), co, so);
    hgt[0] = longint'($signed(pt[108:81])) * 65536;
    hgt[1] = longint'($signed(pt[136:109])) * 65536;
    slm = (sl < 0) ? -sl : sl;
    s2  = umul_shift(slm, slm, 60);
    w   = (64'd1 << 48) - umul_shift({16'd0, ecc_q48}, s2, 60);
    // integer square root of w * 2^64
    rt = 0;
    for (int b = 56; b >= 0; b--) begin
      tt_bit = rt | (64'd1 << b);
      tt = {64'd0, tt_bit} * {64'd0, tt_bit};
      if (tt <= {w, 64'd0}) rt = tt_bit;
    end
    n16 = div_capped({31'd0, axis_mm, 64'd0} << 8, rt);
    p   = {95'd0, axis_mm} * {64'd0, (64'd1 << 48) - {16'd0, ecc_q48}};
    m16 = div_capped(p << 24, rt);
    rn = longint'(n16) + hgt[0];
    rm = longint'(m16) + hgt[0];
    t  = smul_shift(rn, cl, 60);
    res.x_first  = round_mm(smul_shift(t, co, 60));
    res.y_first  = round_mm(smul_shift(t, so, 60));
    res.z_first  = round_mm(smul_shift(rm, sl, 60));
    rn = longint'(n16) + hgt[1];
    rm = longint'(m16) + hgt[1];
    t  = smul_shift(rn, cl, 60);
    res.x_second = round_mm(smul_shift(t, co, 60));
    res.y_second = round_mm(smul_shift(t, so, 60));
    res.z_second = round_mm(smul_shift(rm, sl, 60));
    res.last_point = last;
  endtask

  // ---------------------------------------------------------------------------
  // Input monitor: predicts each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ecef_t res;
    if (rst_n && in_tvalid && in_tready) begin
      convert_point(in_tdata, in_tlast, res);
      ecef_due.push_back(res);
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker: oldest expectation vs. each accepted output beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ecef_t want;
    ecef_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.x_first    = out_tdata[33:0];
      got.y_first    = out_tdata[67:34];
      got.z_first    = out_tdata[101:68];
      got.x_second   = out_tdata[135:102];
      got.y_second   = out_tdata[169:136];
      got.z_second   = out_tdata[203:170];
      got.last_point = out_tlast;
      if (ecef_due.size() == 0) begin
        $error("unexpected output beat");
        errors++;
      end else begin
        want = ecef_due.pop_front();
        points_checked++;
        if (got.x_first !== want.x_first) begin
          $error("x_first: expected %0d, got %0d", want.x_first, got.x_first); errors++;
        end
        if (got.y_first !== want.y_first) begin
          $error("y_first: expected %0d, got %0d", want.y_first, got.y_first); errors++;
        end
        if (got.z_first !== want.z_first) begin
          $error("z_first: expected %0d, got %0d", want.z_first, got.z_first); errors++;
        end
        if (got.x_second !== want.x_second) begin
          $error("x_second: expected %0d, got %0d", want.x_second, got.x_second); errors++;
        end
        if (got.y_second !== want.y_second) begin
          $error("y_second: expected %0d, got %0d", want.y_second, got.y_second); errors++;
        end
        if (got.z_second !== want.z_second) begin
          $error("z_second: expected %0d, got %0d", want.z_second, got.z_second); errors++;
        end
        if (got.last_point !== want.last_point) begin
          $error("last_point_out: expected %0d, got %0d", want.last_point, got.last_point);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // one point beat; valid stays high into the next call unless it idles
  task automatic send_point(input logic [39:0] lat, input logic [40:0] lon,
                            input logic [27:0] h1, input logic [27:0] h2, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {7'd0, h2, h1, lon, lat};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    points_sent++;
  endtask

  // let the pipe empty before touching the ellipsoid
  task automatic drain;
    in_tvalid <= 1'b0;
    while (ecef_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [47:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_AXIS) axis_mm = val[32:0];
    else                 ecc_q48 = val;
  endtask

  task automatic set_ellipsoid(input logic [47:0] axis, input logic [47:0] ecc);
    drain();
    write_reg(CFG_AXIS, axis);
    write_reg(CFG_ECC, ecc);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // poles, equator, date line, wrap-around angles, height and field extremes
  task automatic test_directed;
    send_point(40'(LAT_MAX), 41'(LON_MAX), 28'(H_MAX), 28'(-H_MAX), 1'b0);
    send_point(40'(-LAT_MAX), 41'(-LON_MAX), 28'(-H_MAX), 28'(H_MAX), 1'b1);
    send_point('0, '0, '0, '0, 1'b0);
    send_point(40'(DEG90_Q32 / 2), 41'(DEG90_Q32), 28'd0, 28'd1, 1'b0);
    send_point(40'(-DEG90_Q32 / 2), 41'(-DEG90_Q32), 28'd1000, 28'(-1000), 1'b1);
    // field extremes: angles at the ends of their fields, lat past the poles
    send_point(40'h7F_FFFF_FFFF, 41'h0FF_FFFF_FFFF, 28'h7FF_FFFF, 28'h800_0000, 1'b0);
    send_point(40'h80_0000_0000, 41'h100_0000_0000, 28'h800_0000, 28'h7FF_FFFF, 1'b1);
    send_point(40'(DEG90_Q32 + 1), 41'(DEG360_Q32), 28'd5, 28'd5, 1'b0);
    send_point(40'(DEG90_Q32 * 3), 41'(DEG90_Q32 * 3 - 1), '0, '0, 1'b0);
    send_point(40'(DEG90_Q32 * 2), 41'(-DEG90_Q32 * 2), '0, '0, 1'b1);
    send_point(40'hFF_FFFF_FFFF, 41'h1FF_FFFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF, 1'b1);
    send_point(40'd1, 41'd1, 28'd1, 28'd1, 1'b0);
  endtask

  task automatic test_random_points(input int count, input int idle, input int stall);
    logic [39:0] lat;
    logic [40:0] lon;
    logic [27:0] h1, h2;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) begin
      if ($urandom_range(9) == 0) begin
        // whole field width, every bit
        lat = 40'(rand64()); lon = 41'(rand64()); h1 = 28'($urandom); h2 = 28'($urandom);
      end else begin
        lat = 40'($signed(rand64()) % (LAT_MAX + 1));
        lon = 41'($signed(rand64()) % (LON_MAX + 1));
        h1  = 28'($signed(rand64()) % (H_MAX + 1));
        h2  = 28'($signed(rand64()) % (H_MAX + 1));
      end
      send_point(lat, lon, h1, h2, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    clk = 1'b0; rst_n = 1'b0;
    in_tdata = '0; in_tvalid = 1'b0; in_tlast = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_AXIS; cfg_data = '0;
    axis_mm = AXIS_RESET; ecc_q48 = ECC_RESET;
    points_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset ellipsoid, no idling
    test_directed();
    test_random_points(150, 0, 0);
    // smallest axis, sphere
    set_ellipsoid(48'd6000000000, 48'd0);
    test_directed();
    test_random_points(150, 74, 0);
    // largest in-range axis, e2 at full scale: radius saturates
    set_ellipsoid(48'd6500000000, 48'hFFFF_FFFF_FFFF);
    test_random_points(150, 0, 74);
    // axis field all ones with junk above bit 32, random eccentricity
    set_ellipsoid({15'h5A5A, 33'h1_FFFF_FFFF}, 48'(rand64()));
    test_random_points(150, 17, 17);

    drain();
    $display("covered %0d points, %0d results checked, over four ellipsoids",
             points_sent, points_checked);
    $display("idle mixes: none, sender gaps, receiver stalls, both");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
